// ===== hw/rtl/ordered_array_list_engine_macros.svh =====
// Assertion macros for the ordered array list engine RTL.
// Depends on nothing; included by the top level, which carries the assertions.
`ifndef ORDERED_ARRAY_LIST_ENGINE_MACROS_SVH
`define ORDERED_ARRAY_LIST_ENGINE_MACROS_SVH

`ifndef NO_ASSERTIONS

// A property that must hold at every clock edge outside reset.
`define OALE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// A condition in one cycle that requires an outcome in the next cycle.
`define OALE_ASSERT_NEXT(lbl, clk, rst, cond, outcome) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (outcome)) \
      else $error("next-cycle check failed");

`else

`define OALE_ASSERT(lbl, clk, rst, prop, msg)

`define OALE_ASSERT_NEXT(lbl, clk, rst, cond, outcome)

`endif

`endif

// ===== hw/rtl/oale_pkg.sv =====
// Package for the ordered array list engine: opcodes, status codes,
// default sizes and the control struct that drives the cell row. No dependencies.
package oale_pkg;

   // Default sizes, handed to the top level parameters.
   localparam int DEPTH_DEF       = 64;
   localparam int VALUE_WIDTH_DEF = 32;

   localparam int OPCODE_W = 4;
   localparam int STATUS_W = 3;

   // Request opcodes.
   localparam logic [OPCODE_W-1:0] OP_INS_AT    = 4'd0;
   localparam logic [OPCODE_W-1:0] OP_INS_FRONT = 4'd1;
   localparam logic [OPCODE_W-1:0] OP_INS_BACK  = 4'd2;
   localparam logic [OPCODE_W-1:0] OP_REM_AT    = 4'd3;
   localparam logic [OPCODE_W-1:0] OP_REM_FRONT = 4'd4;
   localparam logic [OPCODE_W-1:0] OP_REM_BACK  = 4'd5;
   localparam logic [OPCODE_W-1:0] OP_REM_VALUE = 4'd6;
   localparam logic [OPCODE_W-1:0] OP_FIND      = 4'd7;
   localparam logic [OPCODE_W-1:0] OP_READ      = 4'd8;
   localparam logic [OPCODE_W-1:0] OP_MAX       = 4'd9;
   localparam logic [OPCODE_W-1:0] OP_MIN       = 4'd10;

   // Response status codes.
   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_BADPOS    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

   // Commands broadcast to every cell of the row; at most one is set.
   typedef struct packed {
      logic rotate;      // every cell takes its right neighbor, the last takes the first
      logic shift_up;    // cells above the position take their left neighbor, the cell at it takes the new value
      logic shift_down;  // cells at and above the position take their right neighbor
   } cell_ctrl_type;

endpackage

// ===== hw/rtl/oale_if.sv =====
// Valid/ready channel interfaces for the request and response transactions.
// Depends on oale_pkg for opcode and status widths and default sizes.
interface oale_req_if
   import oale_pkg::*;
#(
   parameter int POS_W   = $clog2(DEPTH_DEF + 1),
   parameter int VALUE_W = VALUE_WIDTH_DEF
) ();
   logic                      valid;
   logic                      ready;
   logic [OPCODE_W-1:0]       opcode;
   logic signed [VALUE_W-1:0] item_value;
   logic [POS_W-1:0]          position;

   modport source (output valid, output opcode, output item_value, output position,
                   input ready);
   modport sink   (input valid, input opcode, input item_value, input position,
                   output ready);
endinterface

interface oale_rsp_if
   import oale_pkg::*;
#(
   parameter int POS_W   = $clog2(DEPTH_DEF + 1),
   parameter int IDX_W   = $clog2(DEPTH_DEF),
   parameter int VALUE_W = VALUE_WIDTH_DEF
) ();
   logic                      valid;
   logic                      ready;
   logic [STATUS_W-1:0]       status;
   logic signed [VALUE_W-1:0] result_value;
   logic [IDX_W-1:0]          found_position;
   logic [POS_W-1:0]          entry_count;

   modport source (output valid, output status, output result_value,
                   output found_position, output entry_count, input ready);
   modport sink   (input valid, input status, input result_value,
                   input found_position, input entry_count, output ready);
endinterface

// ===== hw/rtl/oale_cell.sv =====
// One storage cell of the list row: holds a single entry and moves it
// to or from its neighbors on command. Depends on oale_pkg.
module oale_cell
   import oale_pkg::*;
#(
   parameter int VW  = VALUE_WIDTH_DEF,
   parameter int CW  = $clog2(DEPTH_DEF + 1),
   parameter int IDX = 0
) (
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  logic [CW-1:0] pos,
   input  logic [VW-1:0] new_value,
   input  logic [VW-1:0] left_value,
   input  logic [VW-1:0] right_value,
   output logic [VW-1:0] value_out
);

   localparam logic [CW-1:0] MY_INDEX = CW'(IDX);

   logic [VW-1:0] value_ff;
   logic [VW-1:0] value_in;

   // Pick the next entry from the broadcast command and this cell's place.
   always_comb begin
      value_in = value_ff;
      if (ctrl.rotate) begin
         value_in = right_value;
      end else if (ctrl.shift_up) begin
         if (MY_INDEX > pos) begin
            value_in = left_value;
         end else if (MY_INDEX == pos) begin
            value_in = new_value;
         end
      end else if (ctrl.shift_down) begin
         if (MY_INDEX >= pos) begin
            value_in = right_value;
         end
      end
   end

   // Entry storage; its content is undefined until written.
   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value_out = value_ff;

endmodule

// ===== hw/rtl/oale_chain.sv =====
// Row of list cells linked to their neighbors, with the last cell wrapping
// to the first so the row can rotate past the head. Depends on oale_pkg, oale_cell.
module oale_chain
   import oale_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF,
   parameter int VW    = VALUE_WIDTH_DEF,
   parameter int CW    = $clog2(DEPTH_DEF + 1)
) (
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  logic [CW-1:0] pos,
   input  logic [VW-1:0] new_value,
   output logic [VW-1:0] head_value
);

   logic [VW-1:0] cell_q [DEPTH];

   // Cell i sees cell i-1 on its left and cell i+1 on its right; cell 0 sees the new value on its left.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [VW-1:0] left_v;
      logic [VW-1:0] right_v;

      if (i == 0) begin : g_first
         assign left_v = new_value;
      end else begin : g_inner_left
         assign left_v = cell_q[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_v = cell_q[0];
      end else begin : g_inner_right
         assign right_v = cell_q[i+1];
      end

      oale_cell #(
         .VW  (VW),
         .CW  (CW),
         .IDX (i)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .pos         (pos),
         .new_value   (new_value),
         .left_value  (left_v),
         .right_value (right_v),
         .value_out   (cell_q[i])
      );
   end

   assign head_value = cell_q[0];

endmodule

// ===== hw/rtl/ordered_array_list_engine.sv =====
// Ordered array list engine: a bounded list of signed values kept in a row of cells, one
// response transaction per request transaction. Inserts, unknown opcodes and requests rejected
// from the count alone answer in the cycle after acceptance: the row shifts in parallel at the
// accepting edge. Remove, find, read, max and min pass through a scan state, where the row
// rotates so that every entry passes the head cell once and the compare logic sees it, then an
// apply state that applies the removal shift and loads the response. One request is in work at
// a time. No clearing pass is needed after reset; only state, count and response valid are cleared.
//
// Top level. Depends on oale_pkg, oale_if, oale_chain and the assertion macro header.
`include "ordered_array_list_engine_macros.svh"

module ordered_array_list_engine
   import oale_pkg::*;
#(
   parameter int DEPTH       = DEPTH_DEF,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input logic      clock,
   input logic      reset,
   oale_req_if.sink   req,
   oale_rsp_if.source rsp
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = $clog2(DEPTH);
   localparam int VW = VALUE_WIDTH;

   localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);
   localparam logic [IW-1:0] K_LAST    = IW'(DEPTH - 1);

   // Controller states.
   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_APPLY = 2'd2;

   logic [1:0]          state_ff,  state_in;
   logic [CW-1:0]       count_ff,  count_in;
   logic [IW-1:0]       k_ff,      k_in;
   logic [OPCODE_W-1:0] op_ff,     op_in;
   logic [VW-1:0]       val_ff,    val_in;
   logic [CW-1:0]       tpos_ff,   tpos_in;
   logic                hit_ff,    hit_in;
   logic [VW-1:0]       res_ff,    res_in;
   logic [IW-1:0]       where_ff,  where_in;

   logic                rsp_valid_ff,  rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [VW-1:0]       rsp_value_ff,  rsp_value_in;
   logic [IW-1:0]       rsp_fpos_ff,   rsp_fpos_in;
   logic [CW-1:0]       rsp_count_ff,  rsp_count_in;
   logic                rsp_load;

   cell_ctrl_type ctrl;
   logic [CW-1:0] chain_pos;
   logic [VW-1:0] chain_value;
   logic [VW-1:0] head_value;

   logic          accept;
   logic          in_range;
   logic [CW-1:0] ins_pos;

   assign req.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp.ready);
   assign accept    = req.valid && req.ready;
   assign in_range  = CW'(k_ff) < count_ff;

   // Insert position for the three insert opcodes.
   always_comb begin
      unique case (req.opcode)
         OP_INS_FRONT: ins_pos = '0;
         OP_INS_BACK:  ins_pos = count_ff;
         default:      ins_pos = req.position;
      endcase
   end

   // Sequencing, the cell row commands and the response contents.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      k_in          = k_ff;
      op_in         = op_ff;
      val_in        = val_ff;
      tpos_in       = tpos_ff;
      hit_in        = hit_ff;
      res_in        = res_ff;
      where_in      = where_ff;
      ctrl          = '0;
      chain_pos     = ins_pos;
      chain_value   = req.item_value;
      rsp_load      = 1'b0;
      rsp_status_in = ST_OK;
      rsp_value_in  = '0;
      rsp_fpos_in   = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in   = req.opcode;
               val_in  = req.item_value;
               tpos_in = req.position;
               hit_in  = 1'b0;
               k_in    = '0;
               unique case (req.opcode)
                  OP_INS_AT, OP_INS_FRONT, OP_INS_BACK: begin
                     rsp_load = 1'b1;
                     if (count_ff == DEPTH_CNT) begin
                        rsp_status_in = ST_FULL;
                     end else if (ins_pos > count_ff) begin
                        rsp_status_in = ST_BADPOS;
                     end else begin
                        ctrl.shift_up = 1'b1;
                        count_in      = count_ff + 1'b1;
                     end
                  end
                  OP_REM_AT, OP_READ: begin
                     if (req.position >= count_ff) begin
                        rsp_load      = 1'b1;
                        rsp_status_in = ST_BADPOS;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  OP_REM_FRONT, OP_REM_BACK, OP_MAX, OP_MIN: begin
                     if (count_ff == '0) begin
                        rsp_load      = 1'b1;
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        state_in = S_SCAN;
                        if (req.opcode == OP_REM_FRONT) begin
                           tpos_in = '0;
                        end else begin
                           tpos_in = count_ff - 1'b1;
                        end
                     end
                  end
                  OP_REM_VALUE, OP_FIND: begin
                     state_in = S_SCAN;
                  end
                  default: begin
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end

         S_SCAN: begin
            // The head cell holds entry k during this cycle.
            ctrl.rotate = 1'b1;
            k_in        = k_ff + 1'b1;
            if (in_range) begin
               unique case (op_ff)
                  OP_REM_VALUE, OP_FIND: begin
                     if (!hit_ff && head_value == val_ff) begin
                        hit_in   = 1'b1;
                        where_in = k_ff;
                        res_in   = head_value;
                     end
                  end
                  OP_MAX: begin
                     if (k_ff == '0 || $signed(head_value) > $signed(res_ff)) begin
                        res_in = head_value;
                     end
                  end
                  OP_MIN: begin
                     if (k_ff == '0 || $signed(head_value) < $signed(res_ff)) begin
                        res_in = head_value;
                     end
                  end
                  default: begin
                     if (CW'(k_ff) == tpos_ff) begin
                        res_in = head_value;
                     end
                  end
               endcase
            end
            if (k_ff == K_LAST) begin
               state_in = S_APPLY;
            end
         end

         S_APPLY: begin
            rsp_load = 1'b1;
            state_in = S_IDLE;
            unique case (op_ff)
               OP_REM_AT, OP_REM_FRONT, OP_REM_BACK: begin
                  ctrl.shift_down = 1'b1;
                  chain_pos       = tpos_ff;
                  count_in        = count_ff - 1'b1;
                  rsp_value_in    = res_ff;
               end
               OP_REM_VALUE: begin
                  if (hit_ff) begin
                     ctrl.shift_down = 1'b1;
                     chain_pos       = CW'(where_ff);
                     count_in        = count_ff - 1'b1;
                     rsp_value_in    = res_ff;
                  end else begin
                     rsp_status_in = ST_NOTFOUND;
                  end
               end
               OP_FIND: begin
                  if (hit_ff) begin
                     rsp_fpos_in = where_ff;
                  end else begin
                     rsp_status_in = ST_NOTFOUND;
                  end
               end
               default: begin
                  rsp_value_in = res_ff;
               end
            endcase
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_count_in = count_in;
   end

   // The response register holds one transaction until the sink takes it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request fields and scan results.
   always_ff @(posedge clock) begin
      k_ff     <= k_in;
      op_ff    <= op_in;
      val_ff   <= val_in;
      tpos_ff  <= tpos_in;
      hit_ff   <= hit_in;
      res_ff   <= res_in;
      where_ff <= where_in;
   end

   // Response payload.
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_value_ff  <= rsp_value_in;
         rsp_fpos_ff   <= rsp_fpos_in;
         rsp_count_ff  <= rsp_count_in;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.status         = rsp_status_ff;
   assign rsp.result_value   = rsp_value_ff;
   assign rsp.found_position = rsp_fpos_ff;
   assign rsp.entry_count    = rsp_count_ff;

   // Cell row that holds the entries.
   oale_chain #(
      .DEPTH (DEPTH),
      .VW    (VW),
      .CW    (CW)
   ) u_chain (
      .clock      (clock),
      .ctrl       (ctrl),
      .pos        (chain_pos),
      .new_value  (chain_value),
      .head_value (head_value)
   );

   // Assertions.
   `OALE_ASSERT(a_count_bound, clock, reset, count_ff <= DEPTH_CNT, "count above depth")
   `OALE_ASSERT(a_count_with_rsp, clock, reset, (count_in != count_ff) |-> rsp_load, "count moved without a response")
   `OALE_ASSERT(a_rsp_no_overwrite, clock, reset, rsp_load |-> (!rsp_valid_ff || rsp.ready), "pending response overwritten")
   `OALE_ASSERT_NEXT(a_scan_step, clock, reset, (state_ff == S_SCAN) && (k_ff != K_LAST), (state_ff == S_SCAN) && (k_ff == $past(k_ff) + 1'b1))
   `OALE_ASSERT_NEXT(a_scan_end, clock, reset, (state_ff == S_SCAN) && (k_ff == K_LAST), state_ff == S_APPLY)

endmodule

// ===== bench/ordered_array_list_engine_tb.sv =====
// Self-checking testbench for the ordered array list engine: directed corner cases, then random
// bursts of list requests against a shadow list that predicts each response transaction.
// Depends on oale_pkg, the oale_req_if/oale_rsp_if interfaces and the engine RTL.
`timescale 1ns / 1ps

module ordered_array_list_engine_tb;
   import oale_pkg::*;

   localparam int LIST_DEPTH   = DEPTH_DEF;
   localparam int VALUE_W      = VALUE_WIDTH_DEF;
   localparam int POS_W        = $clog2(LIST_DEPTH + 1);
   localparam int IDX_W        = $clog2(LIST_DEPTH);
   localparam int RANDOM_ITEMS = 950;
   localparam int PHASE_LEN    = 140;
   localparam int CYCLE_LIMIT  = 1_000_000;

   // Opcodes outside the defined set; the engine must leave the list alone.
   localparam logic [OPCODE_W-1:0] OP_UNUSED_LO = 4'd11;
   localparam logic [OPCODE_W-1:0] OP_UNUSED_HI = 4'd15;

   typedef struct packed {
      logic [OPCODE_W-1:0]       opcode;
      logic signed [VALUE_W-1:0] item_value;
      logic [POS_W-1:0]          position;
   } list_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic signed [VALUE_W-1:0] value;
      logic [IDX_W-1:0]          found_at;
      logic [POS_W-1:0]          count;
   } list_rsp_type;

   typedef enum {FILL_LOAD, MIX_LOAD, DRAIN_LOAD} load_type;
   typedef enum {READY_ALWAYS, READY_COIN, READY_PATTERN, READY_SPARSE} ready_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   oale_req_if req_if ();
   oale_rsp_if rsp_if ();

   ordered_array_list_engine DUT (
      .clock(clock),
      .reset(reset),
      .req  (req_if),
      .rsp  (rsp_if)
   );

   // Shadow copy of the list contents and the request/response bookkeeping.
   logic signed [VALUE_W-1:0] shadow_list [0:LIST_DEPTH-1];
   int                        shadow_count = 0;
   list_req_type              queued_req_q [$];
   list_rsp_type              awaited_rsp_q [$];
   int                        error_count = 0;
   int                        cycle_count = 0;
   int                        burst_left;
   int                        gap_left;
   ready_mode_type            ready_mode;
   int                        mode_left;
   logic [15:0]               stall_pattern;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Removes one entry from the shadow list, closing the hole, and returns it.
   function automatic logic signed [VALUE_W-1:0] take_entry(int at);
      logic signed [VALUE_W-1:0] taken;
      int i;
      taken = shadow_list[at];
      for (i = at; i + 1 < shadow_count; i++)
         shadow_list[i] = shadow_list[i + 1];
      shadow_count--;
      return taken;
   endfunction

   // Applies one request to the shadow list and returns the response it must produce.
   function automatic list_rsp_type apply_list_op(logic [OPCODE_W-1:0] op,
                                                  logic signed [VALUE_W-1:0] val,
                                                  logic [POS_W-1:0] pos);
      list_rsp_type r;
      logic signed [VALUE_W-1:0] best;
      int at;
      int hit;
      int i;
      r = '0;
      r.status = ST_OK;

      // First entry equal to the value, used by find and remove-by-value.
      hit = -1;
      for (i = shadow_count - 1; i >= 0; i--)
         if (shadow_list[i] == val) hit = i;

      case (op)
         OP_INS_AT, OP_INS_FRONT, OP_INS_BACK: begin
            if (op == OP_INS_AT) at = int'(pos);
            else if (op == OP_INS_FRONT) at = 0;
            else at = shadow_count;
            // A full list is reported before the position is looked at.
            if (shadow_count >= LIST_DEPTH) begin
               r.status = ST_FULL;
            end else if (at > shadow_count) begin
               r.status = ST_BADPOS;
            end else begin
               for (i = shadow_count; i > at; i--)
                  shadow_list[i] = shadow_list[i - 1];
               shadow_list[at] = val;
               shadow_count++;
            end
         end
         OP_REM_AT: begin
            if (pos < shadow_count) r.value = take_entry(int'(pos));
            else r.status = ST_BADPOS;
         end
         OP_REM_FRONT: begin
            if (shadow_count > 0) r.value = take_entry(0);
            else r.status = ST_EMPTY;
         end
         OP_REM_BACK: begin
            if (shadow_count > 0) r.value = take_entry(shadow_count - 1);
            else r.status = ST_EMPTY;
         end
         OP_REM_VALUE: begin
            if (hit >= 0) r.value = take_entry(hit);
            else r.status = ST_NOTFOUND;
         end
         OP_FIND: begin
            if (hit >= 0) r.found_at = IDX_W'(hit);
            else r.status = ST_NOTFOUND;
         end
         OP_READ: begin
            if (pos < shadow_count) r.value = shadow_list[pos];
            else r.status = ST_BADPOS;
         end
         OP_MAX, OP_MIN: begin
            if (shadow_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               best = shadow_list[0];
               for (i = 1; i < shadow_count; i++) begin
                  if (op == OP_MAX ? (shadow_list[i] > best) : (shadow_list[i] < best))
                     best = shadow_list[i];
               end
               r.value = best;
            end
         end
         default: ;
      endcase
      r.count = POS_W'(shadow_count);
      return r;
   endfunction

   // Builds one random request; the load shifts the mix toward growing or shrinking the list.
   function automatic list_req_type make_request(load_type load);
      list_req_type r;
      int pick;
      pick = $urandom_range(0, 99);
      case (load)
         FILL_LOAD: begin
            if (pick < 80) r.opcode = OPCODE_W'($urandom_range(OP_INS_AT, OP_INS_BACK));
            else r.opcode = OPCODE_W'($urandom_range(OP_REM_AT, OP_MIN));
         end
         DRAIN_LOAD: begin
            if (pick < 70) r.opcode = OPCODE_W'($urandom_range(OP_REM_AT, OP_REM_VALUE));
            else r.opcode = OPCODE_W'($urandom_range(OP_INS_AT, OP_MIN));
         end
         default: r.opcode = OPCODE_W'($urandom_range(OP_INS_AT, OP_MIN));
      endcase

      // Values: corners, a small pool that produces duplicates, or anything at all.
      pick = $urandom_range(0, 7);
      if (pick == 0) begin
         case ($urandom_range(0, 3))
            0: r.item_value = 32'h8000_0000;
            1: r.item_value = 32'h7fff_ffff;
            2: r.item_value = '0;
            default: r.item_value = '1;
         endcase
      end else if (pick < 4) begin
         r.item_value = VALUE_W'($urandom_range(0, 15) - 8);
      end else begin
         r.item_value = VALUE_W'($urandom);
      end
      // Searches mostly look for a value the list holds.
      if ((r.opcode == OP_FIND || r.opcode == OP_REM_VALUE) && shadow_count > 0
          && $urandom_range(0, 3) != 0)
         r.item_value = shadow_list[$urandom_range(0, shadow_count - 1)];

      // Positions mostly land inside the list, sometimes anywhere in range.
      if ($urandom_range(0, 7) == 0)
         r.position = POS_W'($urandom_range(0, LIST_DEPTH));
      else if (r.opcode == OP_INS_AT)
         r.position = POS_W'($urandom_range(0, shadow_count));
      else
         r.position = POS_W'($urandom_range(0, shadow_count > 0 ? shadow_count - 1 : 0));
      return r;
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   // Waits until every queued request is sent and every response has come back.
   task automatic wait_idle();
      while (queued_req_q.size() > 0 || req_if.valid || awaited_rsp_q.size() > 0)
         @(negedge clock);
   endtask

   // Request driver: bursts of random length separated by random gaps.
   always @(posedge clock) begin
      list_req_type next_req;
      if (reset) begin
         req_if.valid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         // An accepted transaction updates the shadow list and queues its response.
         if (req_if.valid && req_if.ready)
            awaited_rsp_q.push_back(apply_list_op(req_if.opcode, req_if.item_value,
                                                  req_if.position));
         if (!req_if.valid || req_if.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_if.valid <= 1'b0;
            end else if (queued_req_q.size() > 0) begin
               next_req = queued_req_q.pop_front();
               req_if.opcode     <= next_req.opcode;
               req_if.item_value <= next_req.item_value;
               req_if.position   <= next_req.position;
               req_if.valid      <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 15);
                  if ($urandom_range(0, 3) == 0) gap_left = 0;
                  else if ($urandom_range(0, 5) == 0) gap_left = $urandom_range(10, 80);
                  else gap_left = $urandom_range(1, 4);
               end
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Response ready: switches between several stall patterns at random intervals.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         mode_left = 0;
         ready_mode = READY_ALWAYS;
         stall_pattern = '1;
      end else begin
         if (mode_left == 0) begin
            ready_mode = ready_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(50, 400);
            stall_pattern = 16'($urandom) | 16'h0001;
         end else begin
            mode_left--;
         end
         case (ready_mode)
            READY_ALWAYS: rsp_if.ready <= 1'b1;
            READY_COIN:   rsp_if.ready <= 1'($urandom_range(0, 1));
            READY_PATTERN: begin
               rsp_if.ready <= stall_pattern[0];
               stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
            end
            default: rsp_if.ready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   // Response monitor: each transaction is checked against the oldest expectation.
   always @(posedge clock) begin
      list_rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (awaited_rsp_q.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual status %0d value %0h",
                     $time, rsp_if.status, rsp_if.result_value);
            error_count++;
         end else begin
            want = awaited_rsp_q.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_if.status));
            check_field("result_value", want.value, rsp_if.result_value);
            check_field("found_position", 32'(want.found_at), 32'(rsp_if.found_position));
            check_field("entry_count", 32'(want.count), 32'(rsp_if.entry_count));
         end
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Stimulus: directed corner cases first, then random phases that fill and drain the list.
   initial begin
      load_type load;
      int n;
      req_if.valid      = 1'b0;
      req_if.opcode     = OP_INS_AT;
      req_if.item_value = '0;
      req_if.position   = '0;
      rsp_if.ready      = 1'b0;

      // Every request on an empty list that has to fail.
      queued_req_q.push_back(list_req_type'{OP_READ, 32'sd0, 7'd0});
      queued_req_q.push_back(list_req_type'{OP_REM_AT, 32'sd0, 7'd0});
      queued_req_q.push_back(list_req_type'{OP_REM_FRONT, 32'sd0, 7'd0});
      queued_req_q.push_back(list_req_type'{OP_REM_BACK, 32'sd0, 7'd0});
      queued_req_q.push_back(list_req_type'{OP_REM_VALUE, 32'sd5, 7'd0});
      queued_req_q.push_back(list_req_type'{OP_FIND, 32'sd5, 7'd0});
      queued_req_q.push_back(list_req_type'{OP_MAX, 32'sd0, 7'd0});
      queued_req_q.push_back(list_req_type'{OP_MIN, 32'sd0, 7'd0});
      queued_req_q.push_back(list_req_type'{OP_INS_AT, 32'sd9, 7'd1});
      // Build a short list of extreme values, then probe it.
      queued_req_q.push_back(list_req_type'{OP_INS_FRONT, 32'h7fff_ffff, 7'd0});
      queued_req_q.push_back(list_req_type'{OP_INS_BACK, 32'h8000_0000, 7'd0});
      queued_req_q.push_back(list_req_type'{OP_INS_AT, -32'sd1, 7'd1});
      queued_req_q.push_back(list_req_type'{OP_INS_AT, 32'sd0, 7'd3});
      queued_req_q.push_back(list_req_type'{OP_INS_AT, 32'sd7, 7'd64});
      queued_req_q.push_back(list_req_type'{OP_MAX, 32'sd0, 7'd0});
      queued_req_q.push_back(list_req_type'{OP_MIN, 32'sd0, 7'd0});
      queued_req_q.push_back(list_req_type'{OP_FIND, -32'sd1, 7'd0});
      queued_req_q.push_back(list_req_type'{OP_FIND, 32'h8000_0000, 7'd0});
      queued_req_q.push_back(list_req_type'{OP_READ, 32'sd0, 7'd3});
      queued_req_q.push_back(list_req_type'{OP_READ, 32'sd0, 7'd4});
      queued_req_q.push_back(list_req_type'{OP_REM_VALUE, -32'sd1, 7'd0});
      queued_req_q.push_back(list_req_type'{OP_REM_AT, 32'sd0, 7'd1});
      queued_req_q.push_back(list_req_type'{OP_UNUSED_LO, 32'sd3, 7'd0});
      queued_req_q.push_back(list_req_type'{OP_UNUSED_HI, -32'sd1, 7'd64});
      queued_req_q.push_back(list_req_type'{OP_REM_BACK, 32'sd0, 7'd0});

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         // Each phase starts from a quiet engine, which also gives a full pause in sending.
         if (n % PHASE_LEN == 0) begin
            wait_idle();
            case (n / PHASE_LEN)
               0, 3, 5: load = FILL_LOAD;
               2, 6:    load = DRAIN_LOAD;
               default: load = MIX_LOAD;
            endcase
         end
         // Keep the backlog short so requests are built from the current list contents.
         while (queued_req_q.size() >= 2) @(negedge clock);
         queued_req_q.push_back(make_request(load));
      end

      wait_idle();
      repeat (LIST_DEPTH + 8) @(negedge clock);
      if (error_count == 0 && awaited_rsp_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== ordered_array_list_engine.f =====
+incdir+hw/rtl
hw/rtl/oale_pkg.sv
hw/rtl/oale_if.sv
hw/rtl/oale_cell.sv
hw/rtl/oale_chain.sv
hw/rtl/ordered_array_list_engine.sv
bench/ordered_array_list_engine_tb.sv
